>>> design/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants of the multichannel moving average unit.
// ----------------------------------------------------------------------------
package mma_pkg;

	// sample and field widths
	localparam int SAMPLE_W  = 24;
	localparam int SLOT_W    = 4;
	localparam int VALID_BIT = 24;

	// averaged channels: even numbers from first to last
	localparam logic [4:0] CH_FIRST = 5'd4;
	localparam logic [4:0] CH_LAST  = 5'd18;

	// queue depths (powers of two)
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic                active;
		logic                update;
		logic [SLOT_W-1:0]   slot;
		sample_t             sample;
	} item_t;

	// result transaction
	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		sample_t             average;
		logic                updated;
	} result_t;

endpackage

>>> design/multichannel_moving_average_unit.sv
// ----------------------------------------------------------------------------
// multichannel_moving_average_unit
// Boxcar moving average over sensor result words, one window per slot.
// ----------------------------------------------------------------------------
// The unit takes one transaction per cycle while the input queue is not full and
// returns one result per transaction, in order. A transaction passes through the
// item queue and three pipeline stages (row read and update, magnitude,
// reciprocal multiply), after which its result is written into the result queue
// and shown on the result ports. The sustained rate is one transaction per cycle
// while the result queue has room for all items in flight, set by the
// single read-modify-write of the slot's window row, with a bypass when two
// transactions in a row address the same slot. Slot state reads as zero after
// reset through a written mark per slot, so no clearing pass is needed. The
// input queue reports full once it holds MID_DEPTH items, as when the back end waits on the result queue.
module multichannel_moving_average_unit #(
	parameter int WINDOW = 3,
	parameter int SLOTS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [31:0]                     raw_word,
	input  logic [4:0]                      sensor_channel,
	input  logic                            bank,
	input  logic                            update_request,
	output logic                            empty,
	input  logic                            pop,
	output logic [mma_pkg::SLOT_W-1:0]      slot,
	output mma_pkg::sample_t                average,
	output logic                            updated
);
	import mma_pkg::*;

	localparam int ITEM_W = $bits(item_t);
	localparam int RES_W  = $bits(result_t);

	item_t                       item_in;
	item_t                       item_head;
	logic                        item_empty;
	logic                        item_pop;
	logic [$clog2(OUT_DEPTH+1)-1:0] res_count;
	logic                        res_push;
	result_t                     res_in;
	result_t                     res_head;

	// classify incoming transactions
	mma_front #(
		.SLOTS(SLOTS)
	) u_front (
		.raw_word       (raw_word),
		.sensor_channel (sensor_channel),
		.bank           (bank),
		.update_request (update_request),
		.item           (item_in)
	);

	// decouple front and back
	mma_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(MID_DEPTH)
	) u_item_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (item_in),
		.full    (full),
		.pop     (item_pop),
		.rd_data (item_head),
		.empty   (item_empty),
		.count   ()
	);

	// window update and division
	mma_back #(
		.WINDOW(WINDOW),
		.SLOTS (SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_head),
		.item_empty (item_empty),
		.item_pop   (item_pop),
		.res_count  (res_count),
		.res_push   (res_push),
		.res_data   (res_in)
	);

	// hold results until taken
	mma_fifo #(
		.WIDTH(RES_W),
		.DEPTH(OUT_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_in),
		.full    (),
		.pop     (pop),
		.rd_data (res_head),
		.empty   (empty),
		.count   (res_count)
	);

	assign slot    = res_head.slot;
	assign average = res_head.average;
	assign updated = res_head.updated;

endmodule

>>> design/mma_fifo.sv
// ----------------------------------------------------------------------------
// mma_fifo
// Small synchronous queue with a show-ahead head and an occupancy count.
// ----------------------------------------------------------------------------
module mma_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wr_data,
	output logic                         full,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rd_data,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// store the incoming transaction
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/mma_front.sv
// ----------------------------------------------------------------------------
// mma_front
// Classifies an incoming result word: slot address, range check and whether
// the sample is to be taken into the slot's window.
// ----------------------------------------------------------------------------
module mma_front #(
	parameter int SLOTS = 16
) (
	input  logic [31:0]           raw_word,
	input  logic [4:0]            sensor_channel,
	input  logic                  bank,
	input  logic                  update_request,
	output mma_pkg::item_t        item
);
	import mma_pkg::*;

	logic [4:0]        ch_offs;
	logic [SLOT_W-1:0] slot_raw;
	logic              ch_ok;
	logic              slot_ok;

	// decode channel into slot
	always_comb begin
		ch_offs  = sensor_channel - CH_FIRST;
		slot_raw = {bank, ch_offs[3:1]};
		ch_ok    = !sensor_channel[0] && (sensor_channel >= CH_FIRST) &&
		           (sensor_channel <= CH_LAST);
		slot_ok  = ({3'b000, slot_raw} < 7'(SLOTS));
	end

	// build the classified item
	always_comb begin
		item.active = ch_ok && slot_ok;
		item.update = ch_ok && slot_ok && raw_word[VALID_BIT] && update_request;
		item.slot   = (ch_ok && slot_ok) ? slot_raw : '0;
		item.sample = raw_word[SAMPLE_W-1:0];
	end

endmodule

>>> design/mma_back.sv
// ----------------------------------------------------------------------------
// mma_back
// Carries out classified items: read-modify-write of the slot's window row,
// then division of the window sum by the window length.
// ----------------------------------------------------------------------------
module mma_back #(
	parameter int WINDOW = 3,
	parameter int SLOTS  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mma_pkg::item_t                         item,
	input  logic                                   item_empty,
	output logic                                   item_pop,
	input  logic [$clog2(mma_pkg::OUT_DEPTH+1)-1:0] res_count,
	output logic                                   res_push,
	output mma_pkg::result_t                       res_data
);
	import mma_pkg::*;

	localparam int POS_W  = $clog2(WINDOW);
	localparam int SUM_W  = SAMPLE_W + POS_W;
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SHIFT  = SUM_W + POS_W;
	localparam int MULT_W = SUM_W + 1;
	localparam int PROD_W = SUM_W + MULT_W;
	localparam longint unsigned MULT_L =
		((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_L);
	localparam int CNT_W  = $clog2(OUT_DEPTH+1);
	localparam int OCC_W  = CNT_W + 1;

	typedef struct packed {
		logic [POS_W-1:0]        pos;
		logic signed [SUM_W-1:0] sum;
		sample_t [WINDOW-1:0]    ring;
	} row_t;

	// slot memory and its written marks
	row_t              mem_q [SLOTS];
	logic [SLOTS-1:0]  row_vld_q;

	// stage 1: item and slot row
	logic              vld_s1;
	item_t             item_s1;
	logic [IDX_W-1:0]  idx_s1;
	row_t              row_s1;
	logic              hit_s1;

	// stage 2: magnitude of the sum
	logic              vld_s2;
	logic [SLOT_W-1:0] slot_s2;
	logic              upd_s2;
	logic              neg_s2;
	logic [SUM_W-1:0]  mag_s2;

	// stage 3: scaled product
	logic              vld_s3;
	logic [SLOT_W-1:0] slot_s3;
	logic              upd_s3;
	logic              neg_s3;
	logic [PROD_W-1:0] prod_s3;

	logic [IDX_W-1:0]        head_idx;
	logic [OCC_W-1:0]        occ;
	logic                    wr_en;
	row_t                    cur_row;
	row_t                    new_row;
	logic signed [SUM_W-1:0] old_ext;
	logic signed [SUM_W-1:0] new_ext;
	logic signed [SUM_W-1:0] eff_sum;
	logic [SAMPLE_W-1:0]     quo;

	// pop only when the result queue has room for everything in flight
	always_comb begin
		head_idx = IDX_W'(item.slot);
		occ      = OCC_W'(res_count) + OCC_W'(vld_s1) + OCC_W'(vld_s2) +
		           OCC_W'(vld_s3);
		item_pop = !item_empty && (occ < OCC_W'(OUT_DEPTH));
	end

	// update the window row of the slot
	always_comb begin
		cur_row = hit_s1 ? row_s1 : '0;
		old_ext = {{POS_W{cur_row.ring[cur_row.pos][SAMPLE_W-1]}},
		           cur_row.ring[cur_row.pos]};
		new_ext = {{POS_W{item_s1.sample[SAMPLE_W-1]}}, item_s1.sample};
		new_row = cur_row;
		new_row.ring[cur_row.pos] = item_s1.sample;
		new_row.sum = cur_row.sum - old_ext + new_ext;
		new_row.pos = (cur_row.pos == POS_W'(WINDOW-1)) ? '0 : cur_row.pos + 1'b1;
		wr_en   = vld_s1 && item_s1.update;
		if (!item_s1.active) begin
			eff_sum = '0;
		end else if (item_s1.update) begin
			eff_sum = new_row.sum;
		end else begin
			eff_sum = cur_row.sum;
		end
	end

	// write back the updated row
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[idx_s1] <= new_row;
		end
	end

	// read the row of the next item, bypassing a write to the same slot
	always_ff @(posedge clk) begin
		if (item_pop) begin
			item_s1 <= item;
			idx_s1  <= head_idx;
			if (wr_en && (idx_s1 == head_idx)) begin
				row_s1 <= new_row;
				hit_s1 <= 1'b1;
			end else begin
				row_s1 <= mem_q[head_idx];
				hit_s1 <= row_vld_q[head_idx];
			end
		end
	end

	// take magnitude, then multiply by the reciprocal of the window
	always_ff @(posedge clk) begin
		slot_s2 <= item_s1.slot;
		upd_s2  <= wr_en;
		neg_s2  <= eff_sum[SUM_W-1];
		mag_s2  <= eff_sum[SUM_W-1] ? SUM_W'(-eff_sum) : SUM_W'(eff_sum);
		slot_s3 <= slot_s2;
		upd_s3  <= upd_s2;
		neg_s3  <= neg_s2;
		prod_s3 <= PROD_W'(mag_s2) * PROD_W'(MULT);
	end

	// advance stage valids and mark written rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			row_vld_q <= '0;
		end else begin
			vld_s1 <= item_pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (wr_en) begin
				row_vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	// restore the sign of the quotient
	always_comb begin
		quo              = prod_s3[SHIFT +: SAMPLE_W];
		res_push         = vld_s3;
		res_data.slot    = slot_s3;
		res_data.average = neg_s3 ? -quo : quo;
		res_data.updated = upd_s3;
	end

	// result queue never overflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= OCC_W'(OUT_DEPTH))
		else $error("result queue credit exceeded");

	// a row is written only for an active item
	a_write_active: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> item_s1.active)
		else $error("row write for an inactive item");

	// every popped item reaches the result queue after passing stages 1, 2 and 3
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |=> ##2 res_push)
		else $error("item lost in the pipeline");

	// a written row is marked as such
	a_row_mark: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> row_vld_q[$past(idx_s1)])
		else $error("written row not marked");

endmodule
